/* rtl/gibs_pkg.sv */
// Shared types and constants for the greedy IoU box suppression block.
`timescale 1ns / 1ps

package gibs_pkg;

    localparam int FIELD_W = 16;
    localparam int DIM_W   = 15;
    localparam int IDX_W   = 10;
    localparam int IDX_MAX = 1023;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int THR_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = THR_W + UNI_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [FIELD_W-1:0] box_left;
        logic signed [FIELD_W-1:0] box_top;
        logic [DIM_W-1:0]          box_width;
        logic [DIM_W-1:0]          box_height;
        logic                      batch_end;
    } box_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] box_index;
        logic             kept;
        logic             result_end;
        logic             store_overflow;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             alive;
        logic             placed;
        logic             batch_end;
        logic [IDX_W-1:0] box_index;
    } tok_ctrl_t;

endpackage

/* rtl/gibs_cell.sv */
// One suppression cell: holds one kept box and tests each passing box against it.
`timescale 1ns / 1ps

module gibs_cell #(
    parameter int EW = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [gibs_pkg::THR_W-1:0] threshold,
    input  gibs_pkg::tok_ctrl_t       in_ctrl,
    input  logic signed [EW-1:0]      in_left,
    input  logic signed [EW-1:0]      in_top,
    input  logic signed [EW-1:0]      in_right,
    input  logic signed [EW-1:0]      in_bottom,
    input  logic [gibs_pkg::AREA_W-1:0] in_area,
    output gibs_pkg::tok_ctrl_t       out_ctrl,
    output logic signed [EW-1:0]      out_left,
    output logic signed [EW-1:0]      out_top,
    output logic signed [EW-1:0]      out_right,
    output logic signed [EW-1:0]      out_bottom,
    output logic [gibs_pkg::AREA_W-1:0] out_area
);
    import gibs_pkg::*;

    logic signed [EW-1:0] st_left_reg;
    logic signed [EW-1:0] st_top_reg;
    logic signed [EW-1:0] st_right_reg;
    logic signed [EW-1:0] st_bottom_reg;
    logic [AREA_W-1:0]    st_area_reg;
    logic                 occ_reg;
    logic                 occ_next;

    tok_ctrl_t            s1_ctrl_reg;
    logic signed [EW-1:0] s1_left_reg;
    logic signed [EW-1:0] s1_top_reg;
    logic signed [EW-1:0] s1_right_reg;
    logic signed [EW-1:0] s1_bottom_reg;
    logic [AREA_W-1:0]    s1_area_reg;
    logic [AREA_W-1:0]    s1_inter_reg;
    logic [UNI_W-1:0]     s1_uni_reg;
    logic                 s1_cmp_reg;

    tok_ctrl_t            s2_ctrl_reg;
    tok_ctrl_t            s2_ctrl_next;
    logic signed [EW-1:0] s2_left_reg;
    logic signed [EW-1:0] s2_top_reg;
    logic signed [EW-1:0] s2_right_reg;
    logic signed [EW-1:0] s2_bottom_reg;
    logic [AREA_W-1:0]    s2_area_reg;

    logic signed [EW-1:0] lo_x;
    logic signed [EW-1:0] lo_y;
    logic signed [EW-1:0] hi_x;
    logic signed [EW-1:0] hi_y;
    logic signed [EW:0]   dx;
    logic signed [EW:0]   dy;
    logic [DIM_W-1:0]     iw;
    logic [DIM_W-1:0]     ih;
    logic [AREA_W-1:0]    inter;
    logic [UNI_W-1:0]     uni;
    logic                 cmp;

    logic [PROD_W-1:0]    rhs;
    logic [PROD_W-1:0]    lhs;
    logic                 over;
    logic                 alive_next;
    logic                 store;

    // The first stage measures the overlap of the arriving box with the stored one.
    always_comb
    begin
        lo_x  = (in_left > st_left_reg) ? in_left : st_left_reg;
        lo_y  = (in_top > st_top_reg) ? in_top : st_top_reg;
        hi_x  = (in_right < st_right_reg) ? in_right : st_right_reg;
        hi_y  = (in_bottom < st_bottom_reg) ? in_bottom : st_bottom_reg;
        dx    = {hi_x[EW-1], hi_x} - {lo_x[EW-1], lo_x};
        dy    = {hi_y[EW-1], hi_y} - {lo_y[EW-1], lo_y};
        iw    = dx[EW] ? '0 : dx[DIM_W-1:0];
        ih    = dy[EW] ? '0 : dy[DIM_W-1:0];
        inter = AREA_W'(iw) * AREA_W'(ih);
        uni   = UNI_W'(in_area) + UNI_W'(st_area_reg) - UNI_W'(inter);
        cmp   = in_ctrl.valid & in_ctrl.alive & ~in_ctrl.placed & occ_reg;
    end

    // The second stage applies the threshold and decides whether the box settles here.
    always_comb
    begin
        rhs        = PROD_W'(threshold) * PROD_W'(s1_uni_reg);
        lhs        = {{(PROD_W - AREA_W - FRAC_W){1'b0}}, s1_inter_reg, {FRAC_W{1'b0}}};
        over       = lhs > rhs;
        alive_next = s1_ctrl_reg.alive & ~(s1_cmp_reg & over);
        store      = s1_ctrl_reg.valid & alive_next & ~s1_ctrl_reg.placed & ~occ_reg;
    end

    always_comb
    begin
        s2_ctrl_next        = s1_ctrl_reg;
        s2_ctrl_next.alive  = alive_next;
        s2_ctrl_next.placed = s1_ctrl_reg.placed | store;
        occ_next            = occ_reg;
        if (s1_ctrl_reg.valid && s1_ctrl_reg.batch_end)
        begin
            occ_next = 1'b0;
        end
        else if (store)
        begin
            occ_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            occ_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s1_ctrl_reg <= in_ctrl;
            s2_ctrl_reg <= s2_ctrl_next;
            occ_reg     <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_left_reg   <= in_left;
            s1_top_reg    <= in_top;
            s1_right_reg  <= in_right;
            s1_bottom_reg <= in_bottom;
            s1_area_reg   <= in_area;
            s1_inter_reg  <= inter;
            s1_uni_reg    <= uni;
            s1_cmp_reg    <= cmp;
            s2_left_reg   <= s1_left_reg;
            s2_top_reg    <= s1_top_reg;
            s2_right_reg  <= s1_right_reg;
            s2_bottom_reg <= s1_bottom_reg;
            s2_area_reg   <= s1_area_reg;
            if (store)
            begin
                st_left_reg   <= s1_left_reg;
                st_top_reg    <= s1_top_reg;
                st_right_reg  <= s1_right_reg;
                st_bottom_reg <= s1_bottom_reg;
                st_area_reg   <= s1_area_reg;
            end
        end
    end

    assign out_ctrl   = s2_ctrl_reg;
    assign out_left   = s2_left_reg;
    assign out_top    = s2_top_reg;
    assign out_right  = s2_right_reg;
    assign out_bottom = s2_bottom_reg;
    assign out_area   = s2_area_reg;

endmodule

/* rtl/greedy_iou_box_suppression_top.sv */
// Top level of the greedy IoU box suppression block: intake, cell row and result register.
`timescale 1ns / 1ps

// Boxes of one class enter on the box channel in descending score order, one per
// transaction, with batch_end set on the last box of the class. Each box produces one
// transaction on the result channel, in input order, carrying its index in the batch,
// the kept flag, the end mark and the store overflow flag. The threshold register is
// written through the cfg channel, which is always ready; write it only while idle.
// A box passes through a row of MAX_KEPT cells; each cell registers it after the
// overlap multiply and again after the threshold multiply. A box settles in the first
// empty cell it reaches alive. The intake takes no new box while the previous one
// still sits in the intake register, so that each box can see the cells filled before it;
// result_valid is registered from the output of the last cell. When the receiver stalls,
// the whole row holds and no new box is accepted until the result register drains.
// Reset empties all cells, clears the batch position and loads the default threshold.

module greedy_iou_box_suppression_top #(
    parameter int MAX_KEPT   = 64,
    parameter int MAX_BOXES  = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gibs_pkg::THR_W-1:0] cfg_data,
    input  logic                      box_valid,
    output logic                      box_ready,
    input  gibs_pkg::box_in_t         box,
    output logic                      result_valid,
    input  logic                      result_ready,
    output gibs_pkg::result_t         result
);
    import gibs_pkg::*;

    localparam int EW        = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
    localparam int INDEX_TOP = ((MAX_BOXES - 1) < IDX_MAX) ? (MAX_BOXES - 1) : IDX_MAX;
    localparam int RAW_W     = 32;

    logic [THR_W-1:0] thr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             adv;
    logic             box_acc;

    logic [RAW_W-1:0]           left_raw;
    logic [RAW_W-1:0]           top_raw;
    logic signed [COORD_BITS-1:0] left_c;
    logic signed [COORD_BITS-1:0] top_c;
    logic signed [EW-1:0]       left_e;
    logic signed [EW-1:0]       top_e;
    logic signed [EW-1:0]       right_e;
    logic signed [EW-1:0]       bottom_e;
    logic [AREA_W-1:0]          area_e;

    tok_ctrl_t            in_ctrl_reg;
    tok_ctrl_t            in_ctrl_next;
    logic signed [EW-1:0] in_left_reg;
    logic signed [EW-1:0] in_top_reg;
    logic signed [EW-1:0] in_right_reg;
    logic signed [EW-1:0] in_bottom_reg;
    logic [AREA_W-1:0]    in_area_reg;

    tok_ctrl_t            ctrl_bus   [MAX_KEPT+1];
    logic signed [EW-1:0] left_bus   [MAX_KEPT+1];
    logic signed [EW-1:0] top_bus    [MAX_KEPT+1];
    logic signed [EW-1:0] right_bus  [MAX_KEPT+1];
    logic signed [EW-1:0] bottom_bus [MAX_KEPT+1];
    logic [AREA_W-1:0]    area_bus   [MAX_KEPT+1];

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    assign adv       = ~result_valid_reg | result_ready;
    assign box_ready = adv & ~in_ctrl_reg.valid;
    assign box_acc   = box_valid & box_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Coordinates are taken as COORD_BITS-wide two's complement values.
    always_comb
    begin
        left_raw = RAW_W'($unsigned(box.box_left));
        top_raw  = RAW_W'($unsigned(box.box_top));
        left_c   = left_raw[COORD_BITS-1:0];
        top_c    = top_raw[COORD_BITS-1:0];
        left_e   = EW'(left_c);
        top_e    = EW'(top_c);
        right_e  = left_e + $signed({{(EW - DIM_W){1'b0}}, box.box_width});
        bottom_e = top_e + $signed({{(EW - DIM_W){1'b0}}, box.box_height});
        area_e   = AREA_W'(box.box_width) * AREA_W'(box.box_height);
    end

    always_comb
    begin
        in_ctrl_next.valid     = box_acc;
        in_ctrl_next.alive     = 1'b1;
        in_ctrl_next.placed    = 1'b0;
        in_ctrl_next.batch_end = box.batch_end;
        in_ctrl_next.box_index = idx_reg;
        idx_next               = idx_reg;
        if (box_acc)
        begin
            if (box.batch_end)
            begin
                idx_next = '0;
            end
            else if (idx_reg < IDX_W'(INDEX_TOP))
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            in_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            idx_reg     <= idx_next;
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_acc)
        begin
            in_left_reg   <= left_e;
            in_top_reg    <= top_e;
            in_right_reg  <= right_e;
            in_bottom_reg <= bottom_e;
            in_area_reg   <= area_e;
        end
    end

    assign ctrl_bus[0]   = in_ctrl_reg;
    assign left_bus[0]   = in_left_reg;
    assign top_bus[0]    = in_top_reg;
    assign right_bus[0]  = in_right_reg;
    assign bottom_bus[0] = in_bottom_reg;
    assign area_bus[0]   = in_area_reg;

    for (genvar k = 0; k < MAX_KEPT; k++)
    begin : g_cell
        gibs_cell #(
            .EW(EW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .threshold  (thr_reg),
            .in_ctrl    (ctrl_bus[k]),
            .in_left    (left_bus[k]),
            .in_top     (top_bus[k]),
            .in_right   (right_bus[k]),
            .in_bottom  (bottom_bus[k]),
            .in_area    (area_bus[k]),
            .out_ctrl   (ctrl_bus[k+1]),
            .out_left   (left_bus[k+1]),
            .out_top    (top_bus[k+1]),
            .out_right  (right_bus[k+1]),
            .out_bottom (bottom_bus[k+1]),
            .out_area   (area_bus[k+1])
        );
    end

    always_comb
    begin
        result_next.box_index      = ctrl_bus[MAX_KEPT].box_index;
        result_next.kept           = ctrl_bus[MAX_KEPT].alive;
        result_next.result_end     = ctrl_bus[MAX_KEPT].batch_end;
        result_next.store_overflow = ctrl_bus[MAX_KEPT].alive & ~ctrl_bus[MAX_KEPT].placed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= ctrl_bus[MAX_KEPT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the greedy IoU box suppression block.
`timescale 1ns / 1ps

module tb;
    import gibs_pkg::*;

    localparam int MAX_KEPT    = 64;
    localparam int MAX_BOXES   = 1024;
    localparam int COORD_BITS  = 16;
    localparam int LATENCY     = 2 * MAX_KEPT + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 24;

    typedef struct {
        box_in_t b;
        bit      typed;
        result_t want;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data = '0;
    logic             box_valid = 1'b0;
    logic             box_ready;
    box_in_t          box = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;

    logic [THR_W-1:0] thr_q16 = THR_RESET;
    box_in_t          kept_store[MAX_KEPT];
    int               kept_n = 0;
    int               next_pos = 0;
    result_t          pending[$];
    row_t             plan[$];
    int               errors = 0;
    bit               calm = 1'b0;
    int unsigned      cycles = 0;

    greedy_iou_box_suppression_top #(
        .MAX_KEPT(MAX_KEPT),
        .MAX_BOXES(MAX_BOXES),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .box_valid(box_valid),
        .box_ready(box_ready),
        .box(box),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #4 clk = ~clk;

    function automatic bit overlap_exceeds(box_in_t a, box_in_t b);
        longint al, at, bl, bt, aw, ah, bw, bh;
        longint lo_x, lo_y, hi_x, hi_y, iw, ih, inter, uni;
        al = longint'($signed(a.box_left));
        at = longint'($signed(a.box_top));
        bl = longint'($signed(b.box_left));
        bt = longint'($signed(b.box_top));
        aw = a.box_width;
        ah = a.box_height;
        bw = b.box_width;
        bh = b.box_height;
        lo_x = (al > bl) ? al : bl;
        lo_y = (at > bt) ? at : bt;
        hi_x = (al + aw < bl + bw) ? al + aw : bl + bw;
        hi_y = (at + ah < bt + bh) ? at + ah : bt + bh;
        iw = (hi_x - lo_x < 0) ? 0 : hi_x - lo_x;
        ih = (hi_y - lo_y < 0) ? 0 : hi_y - lo_y;
        inter = iw * ih;
        uni = aw * ah + bw * bh - inter;
        if (uni == 0)
            return 1'b0;
        return inter * 65536 > longint'(thr_q16) * uni;
    endfunction

    function automatic result_t judge_box(box_in_t b);
        result_t r;
        bit      keep;
        int      i;
        keep = 1'b1;
        i = 0;
        while (keep && i < kept_n) begin
            if (overlap_exceeds(kept_store[i], b))
                keep = 1'b0;
            i++;
        end
        r.store_overflow = 1'b0;
        if (keep) begin
            if (kept_n < MAX_KEPT) begin
                kept_store[kept_n] = b;
                kept_n++;
            end else begin
                r.store_overflow = 1'b1;
            end
        end
        r.box_index = IDX_W'(next_pos);
        r.kept = keep;
        r.result_end = b.batch_end;
        if (b.batch_end) begin
            kept_n = 0;
            next_pos = 0;
        end else if (next_pos < IDX_MAX) begin
            next_pos++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic add_row(int l, int t, int w, int h, bit e, bit typed, int idx, bit k,
                           bit ovf);
        row_t r;
        r.b.box_left = 16'(l);
        r.b.box_top = 16'(t);
        r.b.box_width = 15'(w);
        r.b.box_height = 15'(h);
        r.b.batch_end = e;
        r.typed = typed;
        r.want.box_index = IDX_W'(idx);
        r.want.kept = k;
        r.want.result_end = e;
        r.want.store_overflow = ovf;
        plan.insert(plan.size(), r);
    endtask

    task automatic send_box(box_in_t b, bit typed, result_t want);
        result_t r;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        box_valid <= 1'b1;
        box <= b;
        @(posedge clk);
        while (!box_ready) @(posedge clk);
        r = judge_box(b);
        pending.insert(pending.size(), typed ? want : r);
    endtask

    task automatic settle();
        box_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        thr_q16 = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] edge_coord();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] edge_dim();
        case ($urandom_range(2))
            0: return 15'd0;
            1: return 15'd1;
            default: return 15'h7FFF;
        endcase
    endfunction

    function automatic box_in_t random_box(int cx, int cy);
        box_in_t b;
        int      pick;
        pick = $urandom_range(99);
        b.box_left = 16'(cx + int'($urandom_range(0, 60)));
        b.box_top = 16'(cy + int'($urandom_range(0, 60)));
        b.box_width = 15'($urandom_range(1, 80));
        b.box_height = 15'($urandom_range(1, 80));
        b.batch_end = 1'b0;
        if (pick >= 60 && pick < 70) begin
            if ($urandom_range(1))
                b.box_width = '0;
            else
                b.box_height = '0;
        end else if (pick >= 70 && pick < 80) begin
            b.box_left = edge_coord();
            b.box_top = edge_coord();
            b.box_width = edge_dim();
            b.box_height = edge_dim();
        end else if (pick >= 80) begin
            b.box_left = 16'($urandom);
            b.box_top = 16'($urandom);
            b.box_width = 15'($urandom);
            b.box_height = 15'($urandom);
        end
        return b;
    endfunction

    task automatic run_batch(int n, bit fill);
        box_in_t b;
        int      cx, cy;
        cx = int'($urandom_range(0, 400)) - 200;
        cy = int'($urandom_range(0, 400)) - 200;
        for (int k = 0; k < n; k++) begin
            if (fill) begin
                b.box_left = 16'(k * 3);
                b.box_top = 16'(cy);
                b.box_width = '0;
                b.box_height = 15'($urandom_range(0, 50));
            end else begin
                b = random_box(cx, cy);
            end
            b.batch_end = (k == n - 1);
            send_box(b, 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (result_valid && result_ready) begin
                if (pending.size() == 0) begin
                    report_mismatch($sformatf("result for box %0d with nothing pending",
                                              result.box_index));
                end else begin
                    want = pending.pop_front();
                    if (result.box_index !== want.box_index)
                        report_mismatch($sformatf("box_index got %0d expected %0d",
                                                  result.box_index, want.box_index));
                    if (result.kept !== want.kept)
                        report_mismatch($sformatf("kept got %0b expected %0b on box %0d",
                                                  result.kept, want.kept, want.box_index));
                    if (result.result_end !== want.result_end)
                        report_mismatch($sformatf("result_end got %0b expected %0b on box %0d",
                                                  result.result_end, want.result_end,
                                                  want.box_index));
                    if (result.store_overflow !== want.store_overflow)
                        report_mismatch($sformatf(
                            "store_overflow got %0b expected %0b on box %0d",
                            result.store_overflow, want.store_overflow, want.box_index));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int              issued;
        int              n;
        logic [THR_W-1:0] thr;

        add_row(0, 0, 10, 10, 0, 1, 0, 1, 0);
        add_row(0, 0, 10, 10, 0, 1, 1, 0, 0);
        add_row(5, 0, 10, 10, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(100, 100, 0, 0, 0, 0, 0, 0, 0);
        add_row(-1, -1, 32767, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 10, 10, 1, 1, 7, 0, 0);
        add_row(3, 3, 0, 0, 0, 1, 0, 1, 0);
        add_row(3, 3, 0, 0, 1, 1, 1, 1, 0);
        add_row(-1, -1, 1, 1, 1, 1, 0, 1, 0);
        add_row(20, 20, 5, 5, 0, 0, 0, 0, 0);
        add_row(22, 20, 5, 5, 0, 0, 0, 0, 0);
        add_row(21, 20, 5, 5, 1, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_box(plan[i].b, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: thr = '0;
                1: thr = '1;
                3: thr = 16'd1;
                4: thr = THR_RESET;
                7: thr = 16'hFFFE;
                default: thr = THR_W'($urandom_range(65535));
            endcase
            write_threshold(thr);
            calm = (ph == 5);
            issued = 0;
            if (ph == 4) begin
                run_batch(MAX_BOXES + 6, 1'b0);
                issued += MAX_BOXES + 6;
            end
            if (ph == 2 || ph == 6) begin
                run_batch(MAX_KEPT + 6, 1'b1);
                issued += MAX_KEPT + 6;
            end
            while (issued < 60) begin
                n = $urandom_range(1, 30);
                run_batch(n, 1'b0);
                issued += n;
            end
        end

        settle();
        calm = 1'b0;
        repeat (LATENCY + 16) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
